// ===== rtl/servo_pulse_pwm_generator_defines.svh =====
// assertion macros for the servo pulse generator checker
`ifndef SERVO_PULSE_PWM_GENERATOR_DEFINES_SVH
`define SERVO_PULSE_PWM_GENERATOR_DEFINES_SVH

// implication that is checked only out of reset
`define SPP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication that is checked only out of reset
`define SPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that is also checked during reset
`define SPP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/spp_pkg.sv =====
// shared types and constants of the servo pulse generator
`timescale 1ns / 1ps

package spp_pkg;

  // counter width of the period timer
  localparam int COUNT_BITS = 16;
  // width used to compare the counter with 16 bit compare values
  localparam int CMP_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int CMPX_W = CMP_W + 1;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_WIDTH  = 2'd1;
  localparam logic [1:0] MODE_RANGED = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_WIDTH = 2'd0;
  localparam logic [1:0] CFG_MAX_WIDTH = 2'd1;
  localparam logic [1:0] CFG_PERIOD    = 2'd2;

  // reset values
  localparam logic [15:0] MIN_WIDTH_RST = 16'd1000;
  localparam logic [15:0] MAX_WIDTH_RST = 16'd2000;
  localparam logic [15:0] PERIOD_RST    = 16'd20000;
  localparam logic [15:0] COMPARE_RST   = 16'd1500;

  // position limits in Q2.14
  localparam logic signed [15:0] POS_MINUS_ONE = -16'sd16384;
  localparam logic signed [15:0] POS_PLUS_ONE  = 16'sd16384;
  localparam logic [15:0]        POS_SPAN      = 16'd32768;
  localparam int                 POS_FRAC      = 15;

  typedef struct packed {
    logic [15:0] min_width;
    logic [15:0] max_width;
    logic [15:0] period_len;
  } spp_cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] width;
    logic        clipped_low;
    logic        clipped_high;
  } spp_entry_t;

endpackage

// ===== rtl/spp_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps

interface spp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [15:0]        width_request;
  logic signed [15:0] position_request;

  modport source (output valid, mode, width_request, position_request, input ready);
  modport sink   (input valid, mode, width_request, position_request, output ready);
endinterface

interface spp_out_if;
  logic        valid;
  logic        ready;
  logic        pwm_level;
  logic        period_start;
  logic [15:0] pending_width;
  logic        clipped_low;
  logic        clipped_high;

  modport source (output valid, pwm_level, period_start, pending_width, clipped_low,
                  clipped_high, input ready);
  modport sink   (input valid, pwm_level, period_start, pending_width, clipped_low,
                  clipped_high, output ready);
endinterface

// ===== rtl/spp_front.sv =====
// front part: takes requests, maps and saturates widths
`timescale 1ns / 1ps

module spp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spp_pkg::spp_cfg_t   cfg_i,
  spp_in_if.sink              req_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output spp_pkg::spp_entry_t push_entry_o
);

  logic               s1_v_q;
  logic [1:0]         s1_mode_q;
  logic [15:0]        s1_width_q;
  logic               s1_lo_q;
  logic               s1_hi_q;
  logic signed [33:0] s1_prod_q;

  logic               pos_lo;
  logic               pos_hi;
  logic [15:0]        pos_off;
  logic signed [16:0] diff;
  logic signed [33:0] prod_d;
  logic               s1_load;

  logic signed [33:0] quot;
  logic signed [33:0] map_sum;
  logic signed [16:0] cand;
  logic signed [16:0] min_s;
  logic signed [16:0] max_s;
  logic signed [16:0] lo_w;
  logic               clo;
  logic               chi;
  logic [15:0]        clamped;

  // position saturation and the mapping product
  always_comb begin
    pos_lo  = req_i.position_request < spp_pkg::POS_MINUS_ONE;
    pos_hi  = req_i.position_request > spp_pkg::POS_PLUS_ONE;
    if (pos_lo) begin
      pos_off = 16'd0;
    end else if (pos_hi) begin
      pos_off = spp_pkg::POS_SPAN;
    end else begin
      pos_off = 16'(req_i.position_request - spp_pkg::POS_MINUS_ONE);
    end
    diff   = $signed({1'b0, cfg_i.max_width}) - $signed({1'b0, cfg_i.min_width});
    prod_d = diff * $signed({1'b0, pos_off});
  end

  assign req_i.ready = !s1_v_q || push_ready_i;
  assign s1_load     = req_i.valid && req_i.ready;

  // stage one valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_v_q <= req_i.valid;
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_mode_q  <= req_i.mode;
      s1_width_q <= req_i.width_request;
      s1_lo_q    <= pos_lo;
      s1_hi_q    <= pos_hi;
      s1_prod_q  <= prod_d;
    end
  end

  // floor of the scaled product, then saturation to the width range
  always_comb begin
    quot    = s1_prod_q >>> spp_pkg::POS_FRAC;
    map_sum = $signed({18'd0, cfg_i.min_width}) + quot;
    min_s   = $signed({1'b0, cfg_i.min_width});
    max_s   = $signed({1'b0, cfg_i.max_width});
    if (s1_mode_q == spp_pkg::MODE_RANGED) begin
      cand = map_sum[16:0];
    end else begin
      cand = $signed({1'b0, s1_width_q});
    end
    clo     = cand < min_s;
    lo_w    = clo ? min_s : cand;
    chi     = lo_w > max_s;
    clamped = chi ? cfg_i.max_width : lo_w[15:0];
  end

  // queue entry
  always_comb begin
    push_entry_o.mode  = s1_mode_q;
    push_entry_o.width = clamped;
    case (s1_mode_q)
      spp_pkg::MODE_WIDTH: begin
        push_entry_o.clipped_low  = clo;
        push_entry_o.clipped_high = chi;
      end
      spp_pkg::MODE_RANGED: begin
        push_entry_o.clipped_low  = clo || s1_lo_q;
        push_entry_o.clipped_high = chi || s1_hi_q;
      end
      default: begin
        push_entry_o.clipped_low  = 1'b0;
        push_entry_o.clipped_high = 1'b0;
      end
    endcase
  end

  assign push_valid_o = s1_v_q;

endmodule

// ===== rtl/spp_queue.sv =====
// short fifo between front and back
`timescale 1ns / 1ps

module spp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  spp_pkg::spp_entry_t push_entry_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output spp_pkg::spp_entry_t pop_entry_o
);

  spp_pkg::spp_entry_t             mem_q [spp_pkg::QUEUE_DEPTH];
  logic [spp_pkg::QPTR_W-1:0]      wr_ptr_q;
  logic [spp_pkg::QPTR_W-1:0]      rd_ptr_q;
  logic [spp_pkg::QCNT_W-1:0]      count_q;
  logic                            push;
  logic                            pop;

  assign push_ready_o = count_q != spp_pkg::QCNT_W'(spp_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== rtl/spp_back.sv =====
// back part: period counter, compare registers and result register
`timescale 1ns / 1ps

module spp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spp_pkg::spp_cfg_t   cfg_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  spp_pkg::spp_entry_t pop_entry_i,
  spp_out_if.source           rsp_o
);

  logic [spp_pkg::COUNT_BITS-1:0] tick_q;
  logic [spp_pkg::COUNT_BITS-1:0] tick_d;
  logic [15:0]                    active_q;
  logic [15:0]                    active_d;
  logic [15:0]                    shadow_q;
  logic [15:0]                    shadow_d;
  logic                           out_v_q;

  logic                           pop;
  logic                           at_zero;
  logic [15:0]                    cmp_sel;
  logic                           level;
  logic                           start;
  logic [spp_pkg::COUNT_BITS:0]   inc;
  logic [15:0]                    period_eff;
  logic                           wrap;

  assign pop_ready_o = !out_v_q || rsp_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  // state update for one request
  always_comb begin
    at_zero    = tick_q == '0;
    period_eff = (cfg_i.period_len == 16'd0) ? 16'd1 : cfg_i.period_len;
    inc        = {1'b0, tick_q} + 1'b1;
    wrap       = inc[spp_pkg::COUNT_BITS] ||
                 (spp_pkg::CMPX_W'(inc) >= spp_pkg::CMPX_W'(period_eff));
    tick_d     = tick_q;
    active_d   = active_q;
    shadow_d   = shadow_q;
    start      = 1'b0;
    cmp_sel    = active_q;
    case (pop_entry_i.mode)
      spp_pkg::MODE_TICK: begin
        if (at_zero) begin
          active_d = shadow_q;
          cmp_sel  = shadow_q;
          start    = 1'b1;
        end
        tick_d = wrap ? '0 : inc[spp_pkg::COUNT_BITS-1:0];
      end
      spp_pkg::MODE_WIDTH, spp_pkg::MODE_RANGED: begin
        shadow_d = pop_entry_i.width;
      end
      default: begin
      end
    endcase
    level = spp_pkg::CMP_W'(tick_q) < spp_pkg::CMP_W'(cmp_sel);
  end

  // timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      active_q <= spp_pkg::COMPARE_RST;
      shadow_q <= spp_pkg::COMPARE_RST;
    end else if (pop) begin
      tick_q   <= tick_d;
      active_q <= active_d;
      shadow_q <= shadow_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (pop_ready_o) begin
      out_v_q <= pop_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rsp_o.pwm_level     <= level;
      rsp_o.period_start  <= start;
      rsp_o.pending_width <= shadow_d;
      rsp_o.clipped_low   <= pop_entry_i.clipped_low;
      rsp_o.clipped_high  <= pop_entry_i.clipped_high;
    end
  end

  assign rsp_o.valid = out_v_q;

endmodule

// ===== rtl/servo_pulse_pwm_generator.sv =====
// servo pulse generator top level
//
// Requests enter on req_i: mode 0 is a timer tick, mode 1 sets a pulse width in
// ticks, mode 2 sets a signed Q2.14 position that is mapped onto the width range.
// Every request gives exactly one result on rsp_o: pin level, period start flag,
// the pending compare value and the two saturation flags.
// Configuration (min_width, max_width, period length) is written through cfg_we_i,
// cfg_index_i and cfg_wdata_i; the user must write it only while no request is in
// flight, as the block itself does not enforce this. One request is accepted every
// cycle while req_i.ready is high. An accepted request is registered in the mapping
// multiplier stage, then written into the front-to-back queue, then loaded into the
// result register; the queue and the result register hold their entries on a stall.
// A new pending width is copied to the active compare when a tick finds the
// counter at zero.
// Reset clears the counter, sets both compare values to 1500 and loads the
// configuration reset values; the queue and the result register come up empty.
// When the receiver stalls, the result holds, the four-entry queue fills and then
// req_i.ready drops until results are taken again.
`timescale 1ns / 1ps

module servo_pulse_pwm_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  spp_in_if.sink      req_i,
  spp_out_if.source   rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  spp_pkg::spp_cfg_t   cfg_q;
  logic                push_valid;
  logic                push_ready;
  spp_pkg::spp_entry_t push_entry;
  logic                pop_valid;
  logic                pop_ready;
  spp_pkg::spp_entry_t pop_entry;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_width  <= spp_pkg::MIN_WIDTH_RST;
      cfg_q.max_width  <= spp_pkg::MAX_WIDTH_RST;
      cfg_q.period_len <= spp_pkg::PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spp_pkg::CFG_MIN_WIDTH: cfg_q.min_width  <= cfg_wdata_i;
        spp_pkg::CFG_MAX_WIDTH: cfg_q.max_width  <= cfg_wdata_i;
        spp_pkg::CFG_PERIOD:    cfg_q.period_len <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // request classification and width mapping
  spp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // decoupling queue
  spp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // timer and compare state
  spp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== rtl/spp_checker.sv =====
// port-level checker of the servo pulse generator and its bind
`timescale 1ns / 1ps
`include "servo_pulse_pwm_generator_defines.svh"

module spp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        pwm_level_i,
  input logic        period_start_i,
  input logic [15:0] pending_width_i,
  input logic        clipped_low_i,
  input logic        clipped_high_i
);

  // a stalled result keeps its payload
  `SPP_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(pending_width_i) && $stable(pwm_level_i) && $stable(period_start_i))

  // a period-start result never carries saturation flags
  `SPP_ASSERT_IMPLY(a_tick_no_clip, clk_i, rst_ni, out_valid_i && period_start_i, !clipped_low_i && !clipped_high_i)

  // nothing is offered right after reset
  `SPP_ASSERT_NEXT_ALWAYS(a_reset_empty, clk_i, !rst_ni, !out_valid_i)

endmodule

bind servo_pulse_pwm_generator spp_checker u_spp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .pwm_level_i     (rsp_o.pwm_level),
  .period_start_i  (rsp_o.period_start),
  .pending_width_i (rsp_o.pending_width),
  .clipped_low_i   (rsp_o.clipped_low),
  .clipped_high_i  (rsp_o.clipped_high)
);
